FILE: rtl/core/mps_pkg.sv
// mps_pkg: shared constants, types and helpers for the matrix power block
// used by mps_ctrl, mps_dp and matrix_power_by_squaring; no dependencies
package mps_pkg;

  // matrix shape and exponent scan length
  localparam int DIM      = 3;
  localparam int EXP_BITS = 16;
  localparam int CELLS    = DIM * DIM;

  // field widths fixed by the stream format
  localparam int WORD_W   = 32;
  localparam int ROW_W    = 2;
  localparam int EXP_W    = 16;
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 40;

  // derived counter and index widths
  localparam int CNT_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int BIT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POWER = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             base_we;
    logic             init_we;
    logic             init_one;
    logic             mac_vld;
    logic             mac_first;
    logic             mac_last;
    logic             b_base;
    logic             rd_bank;
    logic             wr_bank;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic [IDX_W-1:0] dest_idx;
    logic             out_rd;
    logic             out_ld;
    logic [ROW_W-1:0] out_row;
    logic [ROW_W-1:0] out_col;
    logic             out_last;
  } mps_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } mps_sts_t;

  // row-major cell address
  function automatic logic [IDX_W-1:0] cell_idx(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
    cell_idx = IDX_W'(int'(r) * DIM + int'(c));
  endfunction

endpackage

FILE: rtl/core/mps_ctrl.sv
// mps_ctrl: sequencer for load, identity init, the product loop and result emission
// depends on mps_pkg; drives mps_dp through mps_cmd_t
module mps_ctrl
  import mps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  op_t              op,
  input  logic [EXP_W-1:0] exponent,
  input  mps_sts_t         sts,
  output mps_cmd_t         cmd
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIM - 1);

  state_t                state, state_next;
  logic [EXP_BITS-1:0]   exp_q, exp_q_next;
  logic [BIT_W-1:0]      bit_idx, bit_idx_next;
  logic                  phase_mul, phase_mul_next;
  logic                  bank, bank_next;
  logic                  drain, drain_next;
  logic [CNT_W-1:0]      r, r_next;
  logic [CNT_W-1:0]      c, c_next;
  logic [CNT_W-1:0]      k, k_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    exp_q     <= exp_q_next;
    bit_idx   <= bit_idx_next;
    phase_mul <= phase_mul_next;
    bank      <= bank_next;
    drain     <= drain_next;
    r         <= r_next;
    c         <= c_next;
    k         <= k_next;
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    exp_q_next     = exp_q;
    bit_idx_next   = bit_idx;
    phase_mul_next = phase_mul;
    bank_next      = bank;
    drain_next     = drain;
    r_next         = r;
    c_next         = c;
    k_next         = k;
    s_tready       = 1'b0;
    cmd            = '0;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (op == OP_LOAD) begin
            cmd.base_we = 1'b1;
          end else begin
            exp_q_next = exponent[EXP_BITS-1:0];
            bank_next  = 1'b0;
            r_next     = '0;
            c_next     = '0;
            state_next = ST_INIT;
          end
        end
      end

      // write the identity into the current bank
      ST_INIT: begin
        cmd.init_we  = 1'b1;
        cmd.init_one = (r == c);
        cmd.wr_bank  = bank;
        cmd.dest_idx = cell_idx(r, c);
        if (c == LAST_CNT) begin
          c_next = '0;
          if (r == LAST_CNT) begin
            r_next         = '0;
            k_next         = '0;
            bit_idx_next   = BIT_W'(EXP_BITS - 1);
            phase_mul_next = 1'b0;
            state_next     = ST_ISSUE;
          end else begin
            r_next = r + 1'b1;
          end
        end else begin
          c_next = c + 1'b1;
        end
      end

      // one multiply-accumulate term per cycle, k innermost
      ST_ISSUE: begin
        cmd.mac_vld   = 1'b1;
        cmd.mac_first = (k == '0);
        cmd.mac_last  = (k == LAST_CNT);
        cmd.a_idx     = cell_idx(r, k);
        cmd.b_idx     = cell_idx(k, c);
        cmd.b_base    = phase_mul;
        cmd.rd_bank   = bank;
        cmd.wr_bank   = ~bank;
        cmd.dest_idx  = cell_idx(r, c);
        if (k == LAST_CNT) begin
          k_next = '0;
          if (c == LAST_CNT) begin
            c_next = '0;
            if (r == LAST_CNT) begin
              r_next     = '0;
              drain_next = 1'b0;
              state_next = ST_DRAIN;
            end else begin
              r_next = r + 1'b1;
            end
          end else begin
            c_next = c + 1'b1;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end

      // let the last sums reach the write port, then pick the next product or start emission
      ST_DRAIN: begin
        if (!drain) begin
          drain_next = 1'b1;
        end else begin
          bank_next = ~bank;
          if (!phase_mul && exp_q[bit_idx]) begin
            phase_mul_next = 1'b1;
            state_next     = ST_ISSUE;
          end else if (bit_idx == '0) begin
            r_next     = '0;
            c_next     = '0;
            state_next = ST_EMIT_RD;
          end else begin
            bit_idx_next   = bit_idx - 1'b1;
            phase_mul_next = 1'b0;
            state_next     = ST_ISSUE;
          end
        end
      end

      ST_EMIT_RD: begin
        if (sts.out_free) begin
          cmd.out_rd  = 1'b1;
          cmd.rd_bank = bank;
          cmd.a_idx   = cell_idx(r, c);
          state_next  = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        cmd.out_ld   = 1'b1;
        cmd.out_row  = ROW_W'(r);
        cmd.out_col  = ROW_W'(c);
        cmd.out_last = (r == LAST_CNT) && (c == LAST_CNT);
        state_next   = ST_EMIT_RD;
        if (c == LAST_CNT) begin
          c_next = '0;
          if (r == LAST_CNT) begin
            r_next     = '0;
            state_next = ST_IDLE;
          end else begin
            r_next = r + 1'b1;
          end
        end else begin
          c_next = c + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/mps_dp.sv
// mps_dp: base and working matrix stores, shared multiply-accumulate pipe, output register
// depends on mps_pkg; commanded by mps_ctrl
module mps_dp
  import mps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mps_cmd_t                 cmd,
  output mps_sts_t                 sts,
  input  logic [ROW_W-1:0]         ld_row,
  input  logic [ROW_W-1:0]         ld_col,
  input  logic signed [WORD_W-1:0] ld_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ROW_W-1:0]         out_row,
  output logic [ROW_W-1:0]         out_col,
  output logic signed [WORD_W-1:0] out_value,
  output logic                     out_last
);

  // base matrix and two banks of working matrix (accumulator / product)
  logic [WORD_W-1:0] base [CELLS];
  logic [WORD_W-1:0] work [2][CELLS];

  logic [WORD_W-1:0] rd_a, rd_b;
  logic              s1_vld, s1_first, s1_last, s1_bank;
  logic [IDX_W-1:0]  s1_dest;
  logic              s2_vld, s2_first, s2_last, s2_bank;
  logic [IDX_W-1:0]  s2_dest;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] out_word;
  logic              ld_in_range;

  assign ld_in_range = (int'(ld_row) < DIM) && (int'(ld_col) < DIM);

  // base loads
  always_ff @(posedge clk) begin
    if (cmd.base_we && ld_in_range) begin
      base[cell_idx(CNT_W'(ld_row), CNT_W'(ld_col))] <= ld_value;
    end
  end

  // operand reads, registered
  always_ff @(posedge clk) begin
    if (cmd.mac_vld || cmd.out_rd) begin
      rd_a <= work[cmd.rd_bank][cmd.a_idx];
    end
    if (cmd.mac_vld) begin
      rd_b <= cmd.b_base ? base[cmd.b_idx] : work[cmd.rd_bank][cmd.b_idx];
    end
  end

  // pipe control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.mac_vld;
      s2_vld <= s1_vld;
    end
  end

  // pipe payload: multiply, then accumulate
  always_ff @(posedge clk) begin
    s1_first <= cmd.mac_first;
    s1_last  <= cmd.mac_last;
    s1_bank  <= cmd.wr_bank;
    s1_dest  <= cmd.dest_idx;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_bank  <= s1_bank;
    s2_dest  <= s1_dest;
    prod     <= rd_a * rd_b;
    if (s2_vld) begin
      acc <= sum;
    end
  end

  assign sum = s2_first ? prod : acc + prod;

  // working store write port: identity init or finished dot product
  always_ff @(posedge clk) begin
    if (cmd.init_we) begin
      work[cmd.wr_bank][cmd.dest_idx] <= cmd.init_one ? WORD_W'(1) : '0;
    end else if (s2_vld && s2_last) begin
      work[s2_bank][s2_dest] <= sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_row  <= cmd.out_row;
      out_col  <= cmd.out_col;
      out_word <= rd_a;
      out_last <= cmd.out_last;
    end
  end

  assign out_value    = $signed(out_word);
  assign sts.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/core/matrix_power_by_squaring.sv
// matrix_power_by_squaring: top level of the integer matrix power block
// depends on mps_pkg, mps_ctrl and mps_dp
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tuser op; tdata row, col, value, exponent
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata row, col, value; tlast on final entry
//
// a load beat writes its base entry; a power beat runs identity init, then
// 16 + popcount(n) matrix products (27 multiply-accumulates each on the one shared
// multiplier, then a pipe drain), then a read and a load per result beat
// synchronous active-high reset clears the sequencer, pipe and output valid
// a stalled output holds the result walk; no input is taken until it ends
module matrix_power_by_squaring
  import mps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // row_index[1:0], col_index[3:2], elem_value[35:4], exponent[51:36], zero pad
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // op[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_row[1:0], out_col[3:2], out_value[35:4], zero pad
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  mps_cmd_t                 cmd;
  mps_sts_t                 sts;
  op_t                      op;
  logic [ROW_W-1:0]         out_row;
  logic [ROW_W-1:0]         out_col;
  logic signed [WORD_W-1:0] out_value;

  assign op = op_t'(s_axis_tuser);

  mps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .op       (op),
    .exponent (s_axis_tdata[51:36]),
    .sts      (sts),
    .cmd      (cmd)
  );

  mps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .ld_row    (s_axis_tdata[1:0]),
    .ld_col    (s_axis_tdata[3:2]),
    .ld_value  ($signed(s_axis_tdata[35:4])),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_axis_tlast)
  );

  // pack result beat
  assign m_axis_tdata = {4'b0000, out_value, out_col, out_row};

  // output register is never reloaded while a beat still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> !m_axis_tvalid)
    else $error("output register reloaded while holding a beat");

  // input is never taken while the multiply pipe runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !cmd.mac_vld && !cmd.init_we)
    else $error("input ready during matrix work");

  // a result load always comes in the cycle after its read
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> $past(cmd.out_rd))
    else $error("result loaded without a preceding read");

  // the final beat is the bottom-right entry
  a_last_cell: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      (out_row == ROW_W'(DIM - 1)) && (out_col == ROW_W'(DIM - 1)))
    else $error("last marker on wrong entry");

endmodule
